### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check disabled during reset, implication left to the caller
`define ILE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is asserted
`define ILE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ile_pkg.sv
package ile_pkg;

    localparam int ILE_CAPACITY    = 64;
    localparam int ILE_VALUE_WIDTH = 32;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_GET    = 3'd1,
        OP_SET    = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_WRITE,
        CO_INSERT,
        CO_REMOVE,
        CO_READ
    } cell_op_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [7:0]  position;
        logic signed [31:0] item_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         length;
    } out_word_t;

endpackage

### src/ile_cell.sv
module ile_cell
    import ile_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int SLOT_WIDTH  = 6,
    parameter int VALUE_WIDTH = ILE_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  cell_op_t               op,
    input  logic [SLOT_WIDTH-1:0]  slot,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [VALUE_WIDTH-1:0] lo_value,
    input  logic [VALUE_WIDTH-1:0] hi_value,
    output logic [VALUE_WIDTH-1:0] q,
    output logic [VALUE_WIDTH-1:0] rd
);

    localparam logic [SLOT_WIDTH-1:0] MY_IDX = SLOT_WIDTH'(IDX);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;
    logic                   hit;
    logic                   above;

    assign hit   = (slot == MY_IDX);
    assign above = (MY_IDX > slot);
    assign q     = data_reg;
    assign rd    = (op == CO_READ && hit) ? data_reg : '0;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            CO_WRITE:
            begin
                if (hit)
                begin
                    data_next = value;
                end
            end
            CO_INSERT:
            begin
                if (hit)
                begin
                    data_next = value;
                end
                else if (above)
                begin
                    data_next = lo_value;
                end
            end
            CO_REMOVE:
            begin
                if (hit || above)
                begin
                    data_next = hi_value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### src/indexed_list_engine.sv
// channel | signals                 | handshake
// ------- | ----------------------- | ------------------------------------
// command | start, busy, cmd        | word taken when start high, busy low
// result  | done, result            | word valid for the one cycle of done
//
// each word is captured in the idle state, then the cell row acts on it in the exec state
// a new command is taken in the cycle that done is high
// get reads the row through an or tree of per-cell masked values
// reset clears the count and control; cell contents stay undefined
// the receiver cannot stall, so done is never held
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY    = ILE_CAPACITY,
    parameter int VALUE_WIDTH = ILE_VALUE_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  cmd,
    output logic      busy,
    output logic      done,
    output out_word_t result
);

`include "assert_macros.svh"

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                 state_reg;
    logic [2:0]             op_reg;
    logic signed [7:0]      pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   done_reg;
    out_word_t              result_reg;

    logic [63:0]            item_wide;
    logic signed [PW-1:0]   p;
    logic signed [PW-1:0]   nn;
    logic signed [PW-1:0]   np;
    logic                   neg;
    logic                   ok_e;
    logic                   ok_i;
    logic                   full;
    logic [PW-1:0]          slot_e;
    logic [PW-1:0]          slot_i;
    cell_op_t               cell_op;
    logic [SW-1:0]          slot;
    status_t                status;

    logic [VALUE_WIDTH-1:0] q_row  [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_row [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_all;
    logic [63:0]            rd_wide;
    logic [63:0]            len_wide;

    assign busy      = (state_reg == S_EXEC);
    assign done      = done_reg;
    assign result    = result_reg;
    assign item_wide = {32'b0, cmd.item_value};

    // position resolution
    assign p      = {{(PW-8){pos_reg[7]}}, pos_reg};
    assign nn     = {{(PW-CW){1'b0}}, count_reg};
    assign np     = nn + p;
    assign neg    = p[PW-1];
    assign ok_e   = (!neg && (p < nn)) || (neg && (np >= 0));
    assign ok_i   = (!neg && (p <= nn)) || (neg && (np >= 0));
    assign slot_e = neg ? np : p;
    assign slot_i = neg ? (np + PW'(1)) : p;
    assign full   = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        cell_op    = CO_HOLD;
        slot       = slot_e[SW-1:0];
        status     = ST_OK;
        count_next = count_reg;
        if (state_reg == S_EXEC)
        begin
            case (op_reg)
                OP_APPEND:
                begin
                    slot = count_reg[SW-1:0];
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        cell_op    = CO_WRITE;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_GET:
                begin
                    if (ok_e)
                    begin
                        cell_op = CO_READ;
                    end
                    else
                    begin
                        status = ST_RANGE;
                    end
                end
                OP_SET:
                begin
                    if (ok_e)
                    begin
                        cell_op = CO_WRITE;
                    end
                    else
                    begin
                        status = ST_RANGE;
                    end
                end
                OP_INSERT:
                begin
                    slot = slot_i[SW-1:0];
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else if (ok_i)
                    begin
                        cell_op    = CO_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        status = ST_RANGE;
                    end
                end
                OP_REMOVE:
                begin
                    if (ok_e)
                    begin
                        cell_op    = CO_REMOVE;
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        status = ST_RANGE;
                    end
                end
                default:
                begin
                    cell_op = CO_HOLD;
                end
            endcase
        end
    end

    // cell row
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] lo_v;
        logic [VALUE_WIDTH-1:0] hi_v;

        if (k == 0)
        begin : g_first
            assign lo_v = '0;
        end
        else
        begin : g_lo
            assign lo_v = q_row[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign hi_v = '0;
        end
        else
        begin : g_hi
            assign hi_v = q_row[k+1];
        end

        ile_cell #(
            .IDX         (k),
            .SLOT_WIDTH  (SW),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk      (clk),
            .op       (cell_op),
            .slot     (slot),
            .value    (val_reg),
            .lo_value (lo_v),
            .hi_value (hi_v),
            .q        (q_row[k]),
            .rd       (rd_row[k])
        );
    end

    always_comb
    begin
        rd_all = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            rd_all = rd_all | rd_row[k];
        end
    end

    assign rd_wide  = 64'(rd_all);
    assign len_wide = {{(64-CW){1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    count_reg <= count_next;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload and result capture
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg  <= cmd.opcode;
            pos_reg <= cmd.position;
            val_reg <= item_wide[VALUE_WIDTH-1:0];
        end
        if (state_reg == S_EXEC)
        begin
            result_reg.read_value <= rd_wide[31:0];
            result_reg.status     <= status;
            result_reg.length     <= len_wide[6:0];
        end
    end

    `ILE_ASSERT(a_done_idle, clk, rst_n, done |-> !busy, "result strobe while busy")
    `ILE_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> (busy && !done),
        "accepted command did not start")
    `ILE_ASSERT(a_count_cap, clk, rst_n, count_reg <= CW'(CAPACITY), "count above capacity")
    `ILE_ASSERT(a_full_count, clk, rst_n,
        (done && result.status == ST_FULL) |-> full, "full status with room left")
    `ILE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> (!busy && !done), "active during reset")

endmodule

### tb/indexed_list_engine_test.sv
`timescale 1ns / 100ps

module indexed_list_engine_test;
    import ile_pkg::*;

    localparam int         CAP         = ILE_CAPACITY;
    localparam int         STALL_LIMIT = 2000;
    localparam int         MAX_REPORTS = 10;
    localparam logic [2:0] OP_VOID_A   = 3'd5;
    localparam logic [2:0] OP_VOID_B   = 3'd6;
    localparam logic [2:0] OP_VOID_C   = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_word_t  cmd;
    logic      busy;
    logic      done;
    out_word_t result;

    // shadow copy of the list
    logic signed [31:0] list_mem [CAP];
    int                 list_len;

    out_word_t pending_results [$];
    int        mismatches;
    int        words_sent;
    int        range_seen;
    int        full_seen;
    int        peak_len;
    int        stall_cycles;
    bit        no_idle;

    indexed_list_engine u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit find_entry(int p, output int slot);
        if (p >= 0 && p < list_len)
        begin
            slot = p;
            return 1'b1;
        end
        if (p < 0 && -p <= list_len)
        begin
            slot = list_len + p;
            return 1'b1;
        end
        slot = 0;
        return 1'b0;
    endfunction

    function automatic bit find_gap(int p, output int slot);
        if (p >= 0 && p <= list_len)
        begin
            slot = p;
            return 1'b1;
        end
        if (p < 0 && -p <= list_len)
        begin
            slot = list_len + p + 1;
            return 1'b1;
        end
        slot = 0;
        return 1'b0;
    endfunction

    function automatic out_word_t apply_list_op(in_word_t w);
        out_word_t res;
        status_t   st;
        int        p;
        int        slot;
        res = '0;
        st  = ST_OK;
        p   = $signed(w.position);
        case (w.opcode)
            OP_APPEND:
            begin
                if (list_len >= CAP)
                    st = ST_FULL;
                else
                begin
                    list_mem[list_len] = w.item_value;
                    list_len++;
                end
            end
            OP_GET:
            begin
                if (find_entry(p, slot))
                    res.read_value = list_mem[slot];
                else
                    st = ST_RANGE;
            end
            OP_SET:
            begin
                if (find_entry(p, slot))
                    list_mem[slot] = w.item_value;
                else
                    st = ST_RANGE;
            end
            OP_INSERT:
            begin
                if (list_len >= CAP)
                    st = ST_FULL;
                else if (find_gap(p, slot))
                begin
                    for (int k = list_len; k > slot; k--)
                        list_mem[k] = list_mem[k - 1];
                    list_mem[slot] = w.item_value;
                    list_len++;
                end
                else
                    st = ST_RANGE;
            end
            OP_REMOVE:
            begin
                if (find_entry(p, slot))
                begin
                    for (int k = slot; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k + 1];
                    list_len--;
                end
                else
                    st = ST_RANGE;
            end
            default:
            begin
            end
        endcase
        res.status = st;
        res.length = list_len[6:0];
        return res;
    endfunction

    function automatic in_word_t make_word(logic [2:0] op, int pos, logic [31:0] val);
        in_word_t w;
        w.opcode     = op;
        w.position   = pos[7:0];
        w.item_value = val;
        return w;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        if ($urandom_range(99) < 10)
        begin
            case ($urandom_range(3))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h0000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end
        else
            v = $urandom;
        return v;
    endfunction

    function automatic int pick_position(bit for_insert);
        logic signed [7:0] raw;
        int                hi;
        if ($urandom_range(99) < 15 || (list_len == 0 && !for_insert))
        begin
            raw = 8'($urandom_range(255));
            return int'(raw);
        end
        hi = for_insert ? list_len : list_len - 1;
        if ($urandom_range(1) == 0 || list_len == 0)
            return $urandom_range(hi, 0);
        return -int'($urandom_range(list_len, 1));
    endfunction

    // drive one word and wait for it to be taken
    task automatic send_word(in_word_t w);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 30)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd   <= w;
        start <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_results.insert(pending_results.size(), apply_list_op(w));
        words_sent++;
        if (list_len > peak_len)
            peak_len = list_len;
    endtask

    task automatic send_op(logic [2:0] op, int pos, logic [31:0] val);
        send_word(make_word(op, pos, val));
    endtask

    task automatic run_random_ops(int count, int grow_pct, int shrink_pct);
        int          r;
        logic [2:0]  op;
        logic [31:0] val;
        int          pos;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
            begin
                case ($urandom_range(2))
                    0: op = OP_VOID_A;
                    1: op = OP_VOID_B;
                    default: op = OP_VOID_C;
                endcase
            end
            else if (r < 3 + grow_pct)
                op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
            else if (r < 3 + grow_pct + shrink_pct)
                op = OP_REMOVE;
            else
                op = $urandom_range(1) ? OP_GET : OP_SET;
            if (op == OP_APPEND || op > OP_REMOVE)
            begin
                logic signed [7:0] raw;
                raw = 8'($urandom_range(255));
                pos = int'(raw);
            end
            else
                pos = pick_position(op == OP_INSERT);
            val = pick_value();
            send_op(op, pos, val);
        end
    endtask

    task automatic test_directed();
        send_op(OP_GET, 0, 32'h1111_1111);
        send_op(OP_REMOVE, -1, 32'h0);
        send_op(OP_INSERT, -1, 32'h2222_2222);
        send_op(OP_SET, 0, 32'h3333_3333);
        send_op(OP_INSERT, 0, 32'h7fff_ffff);
        send_op(OP_APPEND, -128, 32'h8000_0000);
        send_op(OP_APPEND, 127, 32'hffff_ffff);
        send_op(OP_INSERT, 3, 32'h0000_0000);
        send_op(OP_INSERT, -1, 32'h1234_5678);
        send_op(OP_INSERT, -5, 32'ha5a5_a5a5);
        send_op(OP_INSERT, 7, 32'h4444_4444);
        send_op(OP_GET, -6, 32'h0);
        send_op(OP_GET, -7, 32'h0);
        send_op(OP_GET, 5, 32'h0);
        send_op(OP_GET, 6, 32'h0);
        send_op(OP_GET, 127, 32'hffff_ffff);
        send_op(OP_GET, -128, 32'h0);
        send_op(OP_SET, -1, 32'h5a5a_5a5a);
        send_op(OP_REMOVE, 0, 32'h0);
        send_op(OP_REMOVE, -1, 32'h0);
        send_op(OP_REMOVE, 4, 32'h0);
        send_op(OP_VOID_A, -128, 32'hffff_ffff);
        send_op(OP_VOID_B, 127, 32'h8000_0000);
        send_op(OP_VOID_C, 0, 32'h7fff_ffff);
        send_op(OP_GET, 64, 32'h0);
        send_op(OP_GET, -64, 32'h0);
    endtask

    task automatic test_full_list();
        while (list_len < CAP)
            send_op(OP_APPEND, 0, pick_value());
        // full is reported ahead of a bad position
        send_op(OP_APPEND, 0, 32'h0bad_0001);
        send_op(OP_INSERT, 0, 32'h0bad_0002);
        send_op(OP_INSERT, 127, 32'h0bad_0003);
        send_op(OP_INSERT, -128, 32'h0bad_0004);
        send_op(OP_GET, 63, 32'h0);
        send_op(OP_GET, -64, 32'h0);
        send_op(OP_GET, 64, 32'h0);
        send_op(OP_SET, -64, 32'h8000_0000);
        send_op(OP_SET, 63, 32'h7fff_ffff);
        send_op(OP_REMOVE, 63, 32'h0);
        send_op(OP_INSERT, -63, 32'hcafe_0000);
        send_op(OP_GET, 0, 32'h0);
        send_op(OP_REMOVE, -64, 32'h0);
        send_op(OP_INSERT, 63, 32'hcafe_0001);
        while (list_len > 0)
            send_op(OP_REMOVE, $urandom_range(1) ? 0 : -1, 32'h0);
        send_op(OP_REMOVE, 0, 32'h0);
    endtask

    task automatic test_random_mix();
        run_random_ops(600, 30, 25);
    endtask

    task automatic test_fill_and_drain();
        run_random_ops(150, 70, 10);
        run_random_ops(150, 10, 70);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_random_ops(300, 35, 30);
        no_idle = 1'b0;
    endtask

    // result checking
    always @(posedge clk)
    begin
        out_word_t exp_word;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word: value %0d status %0d length %0d",
                             $signed(result.read_value), result.status, result.length);
            end
            else
            begin
                exp_word = pending_results.pop_front();
                if (result.read_value !== exp_word.read_value
                    || result.status !== exp_word.status
                    || result.length !== exp_word.length)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: value %0d/%0d status %0d/%0d length %0d/%0d",
                                 $signed(exp_word.read_value), $signed(result.read_value),
                                 exp_word.status, result.status,
                                 exp_word.length, result.length);
                end
                if (exp_word.status == ST_RANGE)
                    range_seen++;
                if (exp_word.status == ST_FULL)
                    full_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("[indexed_list_engine] ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        list_len   = 0;
        mismatches = 0;
        words_sent = 0;
        range_seen = 0;
        full_seen  = 0;
        peak_len   = 0;
        no_idle    = 1'b0;
        for (int i = 0; i < CAP; i++)
            list_mem[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_list();
        test_random_mix();
        test_fill_and_drain();
        test_back_to_back();

        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge clk);

        $display("%0d command words checked, peak length %0d of %0d", words_sent,
                 peak_len, CAP);
        $display("%0d out-of-range and %0d list-full results, %0d mismatches", range_seen,
                 full_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[indexed_list_engine] OK");
        else
            $display("[indexed_list_engine] ERROR");
        $finish;
    end

endmodule

### indexed_list_engine.f
+incdir+src
src/ile_pkg.sv
src/ile_cell.sv
src/indexed_list_engine.sv
tb/indexed_list_engine_test.sv
